// File: rtl/gbl_pkg.sv
package gbl_pkg;

  // field widths
  localparam int unsigned POS_W   = 24;
  localparam int unsigned HALF_W  = 23;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned TOT_W   = 17;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // datapath widths
  localparam int unsigned MAG_W   = POS_W + 1;          // pos - origin
  localparam int unsigned DIFF_W  = POS_W + 2;          // pos - origin +/- half
  localparam int unsigned PROD_W  = MAG_W + INV_W;
  localparam int unsigned Q_W     = 16;                 // saturated bin magnitude
  localparam int unsigned BIN_W   = Q_W + 1;            // signed bin
  localparam int unsigned SPAN_W  = BIN_W + 1;          // raw bin difference
  localparam int unsigned TOP_W   = SPAN_W + 1;         // lower corner plus span
  localparam int unsigned FLAT_W  = 27;                 // zb * ny + yb
  localparam int unsigned SPROD_W = 2 * CNT_W;          // bz * ny

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned LANE_C    = 0;
  localparam int unsigned LANE_LO   = 1;
  localparam int unsigned LANE_HI   = 2;

  localparam int unsigned AXIS_STAGES = 4;
  localparam int unsigned COMB_STAGES = 3;
  localparam int unsigned N_STAGES    = AXIS_STAGES + COMB_STAGES;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam int unsigned MAX_AXIS_BINS_DEF   = 256;
  localparam int unsigned COORD_FRAC_BITS_DEF = 8;

  localparam logic [INV_W-1:0] INV_STEP_RST = 24'h010000;
  localparam logic [TOT_W-1:0] TOT_MAX      = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_Y   = 3'd0,
    CFG_ORIGIN_Z   = 3'd1,
    CFG_INV_STEP_Y = 3'd2,
    CFG_INV_STEP_Z = 3'd3,
    CFG_COUNT_Y    = 3'd4,
    CFG_COUNT_Z    = 3'd5,
    CFG_TOTAL_BINS = 3'd6
  } cfg_idx_e;

  // effective grid settings
  typedef struct packed {
    logic [POS_W-1:0] origin_y;
    logic [POS_W-1:0] origin_z;
    logic [INV_W-1:0] inv_y;
    logic [INV_W-1:0] inv_z;
    logic [CNT_W-1:0] ny;
    logic [CNT_W-1:0] nz;
    logic [TOT_W-1:0] nt;
  } gbl_cfg_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [7:0]  area_span_z;
    logic [7:0]  area_span_y;
    logic [15:0] area_start;
    logic [7:0]  cell_z;
    logic [7:0]  cell_y;
    logic        outside;
    logic [15:0] flat_bin;
  } gbl_res_t;

  // clamp a signed bin to 0..n-1
  function automatic logic [CNT_W-1:0] clamp_bin(logic signed [BIN_W-1:0] v,
                                                 logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    if (v[BIN_W-1]) begin
      r = '0;
    end else if ({1'b0, v[Q_W-1:0]} >= BIN_W'(n)) begin
      r = n - CNT_W'(1);
    end else begin
      r = v[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/gbl_cfg_regs.sv
module gbl_cfg_regs import gbl_pkg::*; #(
  parameter int unsigned MAX_AXIS_BINS = MAX_AXIS_BINS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output gbl_cfg_t             cfg_o
);

  logic [POS_W-1:0] origin_y_q, origin_z_q;
  logic [INV_W-1:0] inv_y_q, inv_z_q;
  logic [CNT_W-1:0] count_y_q, count_z_q;
  logic [TOT_W-1:0] total_q;

  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > 32'(MAX_AXIS_BINS)) begin
      r = CNT_W'(MAX_AXIS_BINS);
    end else begin
      r = c;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_y_q <= '0;
      origin_z_q <= '0;
      inv_y_q    <= INV_STEP_RST;
      inv_z_q    <= INV_STEP_RST;
      count_y_q  <= CNT_W'(1);
      count_z_q  <= CNT_W'(1);
      total_q    <= TOT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_Y:   origin_y_q <= cfg_wdata_i[POS_W-1:0];
        CFG_ORIGIN_Z:   origin_z_q <= cfg_wdata_i[POS_W-1:0];
        CFG_INV_STEP_Y: inv_y_q    <= cfg_wdata_i[INV_W-1:0];
        CFG_INV_STEP_Z: inv_z_q    <= cfg_wdata_i[INV_W-1:0];
        CFG_COUNT_Y:    count_y_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_COUNT_Z:    count_z_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_TOTAL_BINS: total_q    <= cfg_wdata_i[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.origin_y = origin_y_q;
    cfg_o.origin_z = origin_z_q;
    cfg_o.inv_y    = inv_y_q;
    cfg_o.inv_z    = inv_z_q;
    cfg_o.ny       = eff_count(count_y_q);
    cfg_o.nz       = eff_count(count_z_q);
    if (total_q == '0) begin
      cfg_o.nt = TOT_W'(1);
    end else if (total_q > TOT_MAX) begin
      cfg_o.nt = TOT_MAX;
    end else begin
      cfg_o.nt = total_q;
    end
  end

endmodule

// File: rtl/gbl_axis.sv
module gbl_axis import gbl_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic [AXIS_STAGES-1:0]  en_i,
  input  logic [POS_W-1:0]        pos_i,
  input  logic [HALF_W-1:0]       half_i,
  input  logic [POS_W-1:0]        origin_i,
  input  logic [INV_W-1:0]        inv_i,
  output logic signed [BIN_W-1:0] bin_c_o,
  output logic signed [BIN_W-1:0] bin_lo_o,
  output logic signed [BIN_W-1:0] bin_hi_o
);

  localparam int unsigned PROD_SHIFT = COORD_FRAC_BITS + 16;

  logic signed [MAG_W-1:0]  r_q;
  logic [HALF_W-1:0]        h_q;
  logic signed [DIFF_W-1:0] diff [NUM_LANES];
  logic [MAG_W-1:0]         mag_q [NUM_LANES];
  logic [NUM_LANES-1:0]     neg_b_q, neg_c_q;
  logic [PROD_W-1:0]        prod_q [NUM_LANES];
  logic signed [BIN_W-1:0]  bin_q [NUM_LANES];

  // stage a: offset from grid origin
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q <= MAG_W'($signed(pos_i)) - MAG_W'($signed(origin_i));
      h_q <= half_i;
    end
  end

  always_comb begin
    diff[LANE_C]  = DIFF_W'(r_q);
    diff[LANE_LO] = DIFF_W'(r_q) - DIFF_W'(h_q);
    diff[LANE_HI] = DIFF_W'(r_q) + DIFF_W'(h_q);
  end

  // stage b: sign and magnitude, stage c: scale, stage d: truncate and saturate
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (en_i[1]) begin
        neg_b_q[i] <= diff[i][DIFF_W-1];
        mag_q[i]   <= diff[i][DIFF_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
      end
      if (en_i[2]) begin
        neg_c_q[i] <= neg_b_q[i];
        prod_q[i]  <= PROD_W'(mag_q[i]) * PROD_W'(inv_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        logic [PROD_W-1:0] sh;
        logic [Q_W-1:0]    q;
        sh = prod_q[i] >> PROD_SHIFT;
        q  = (|sh[PROD_W-1:Q_W]) ? '1 : sh[Q_W-1:0];
        bin_q[i] <= neg_c_q[i] ? -$signed(BIN_W'(q)) : $signed(BIN_W'(q));
      end
    end
  end

  assign bin_c_o  = bin_q[LANE_C];
  assign bin_lo_o = bin_q[LANE_LO];
  assign bin_hi_o = bin_q[LANE_HI];

endmodule

// File: rtl/gbl_combine.sv
module gbl_combine import gbl_pkg::*; (
  input  logic                    clk_i,
  input  logic [COMB_STAGES-1:0]  en_i,
  input  gbl_cfg_t                cfg_i,
  input  logic signed [BIN_W-1:0] yb_i,
  input  logic signed [BIN_W-1:0] ylo_i,
  input  logic signed [BIN_W-1:0] yhi_i,
  input  logic signed [BIN_W-1:0] zb_i,
  input  logic signed [BIN_W-1:0] zlo_i,
  input  logic signed [BIN_W-1:0] zhi_i,
  output gbl_res_t                res_o
);

  // stage e
  logic signed [BIN_W-1:0]  yb_e_q, zb_e_q;
  logic [CNT_W-1:0]         cy_e_q, cz_e_q, by_e_q, bz_e_q;
  logic [SPAN_W-1:0]        sy_e_q, sz_e_q;
  // stage f
  logic signed [BIN_W-1:0]  yb_f_q;
  logic signed [FLAT_W-1:0] fprod_f_q;
  logic [SPROD_W-1:0]       sprod_f_q;
  logic [CNT_W-1:0]         cy_f_q, cz_f_q, by_f_q, bz_f_q;
  logic [SPAN_W-1:0]        sy_f_q, sz_f_q;
  logic signed [TOP_W-1:0]  ytop_f_q, ztop_f_q;
  // stage g
  gbl_res_t                 res_q;

  logic signed [FLAT_W-1:0] flat;
  logic                     out_lo, out_hi;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      yb_e_q <= yb_i;
      zb_e_q <= zb_i;
      cy_e_q <= clamp_bin(yb_i, cfg_i.ny);
      cz_e_q <= clamp_bin(zb_i, cfg_i.nz);
      by_e_q <= clamp_bin(ylo_i, cfg_i.ny);
      bz_e_q <= clamp_bin(zlo_i, cfg_i.nz);
      sy_e_q <= SPAN_W'(yhi_i) - SPAN_W'(ylo_i);
      sz_e_q <= SPAN_W'(zhi_i) - SPAN_W'(zlo_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      yb_f_q    <= yb_e_q;
      fprod_f_q <= FLAT_W'(zb_e_q) * FLAT_W'($signed({1'b0, cfg_i.ny}));
      sprod_f_q <= SPROD_W'(bz_e_q) * SPROD_W'(cfg_i.ny);
      cy_f_q    <= cy_e_q;
      cz_f_q    <= cz_e_q;
      by_f_q    <= by_e_q;
      bz_f_q    <= bz_e_q;
      sy_f_q    <= sy_e_q;
      sz_f_q    <= sz_e_q;
      // lower corner plus raw span, checked against the upper edge next
      ytop_f_q  <= TOP_W'(by_e_q) + TOP_W'($signed(sy_e_q));
      ztop_f_q  <= TOP_W'(bz_e_q) + TOP_W'($signed(sz_e_q));
    end
  end

  always_comb begin
    flat   = fprod_f_q + FLAT_W'(yb_f_q);
    out_lo = flat[FLAT_W-1];
    out_hi = !flat[FLAT_W-1] && (flat[FLAT_W-2:0] >= (FLAT_W-1)'(cfg_i.nt));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      priority if (out_lo) begin
        res_q.flat_bin <= '0;
      end else if (out_hi) begin
        res_q.flat_bin <= 16'(cfg_i.nt - TOT_W'(1));
      end else begin
        res_q.flat_bin <= flat[15:0];
      end
      res_q.outside    <= out_lo | out_hi;
      res_q.cell_y     <= cy_f_q[7:0];
      res_q.cell_z     <= cz_f_q[7:0];
      res_q.area_start <= sprod_f_q[15:0] + 16'(by_f_q);
      res_q.area_span_y <= (ytop_f_q >= TOP_W'($signed({1'b0, cfg_i.ny})))
                           ? 8'(cfg_i.ny - CNT_W'(1) - by_f_q) : sy_f_q[7:0];
      res_q.area_span_z <= (ztop_f_q >= TOP_W'($signed({1'b0, cfg_i.nz})))
                           ? 8'(cfg_i.nz - CNT_W'(1) - bz_f_q) : sz_f_q[7:0];
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/grid_bin_lookup_top.sv
// channel   direction  handshake                        payload
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o  s_axis_tdata_i (query point)
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i  m_axis_tdata_o (bin lookup result)
// cfg       in         cfg_we_i                         cfg_idx_i, cfg_wdata_i
//
// seven register stages from input transfer to result
// one item per cycle sustained while the output is not stalled, every stage then takes a new item each cycle
// a stage takes a new item when it is empty or its successor moves on, so
// bubbles close up under a stall and nothing is dropped or repeated
// reset clears the stage valid bits and loads the grid register defaults
module grid_bin_lookup_top import gbl_pkg::*; #(
  parameter int unsigned MAX_AXIS_BINS   = MAX_AXIS_BINS_DEF,
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // pos_y[23:0], pos_z[47:24], half_y[70:48], half_z[93:71], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // flat_bin[15:0], outside[16], cell_y[24:17], cell_z[32:25],
  // area_start[48:33], area_span_y[56:49], area_span_z[64:57], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  gbl_cfg_t              cfg;
  gbl_res_t              res;
  logic [N_STAGES-1:0]   vld_q, vld_d;
  logic [N_STAGES:0]     rdy;
  logic signed [BIN_W-1:0] yb, ylo, yhi, zb, zlo, zhi;

  always_comb begin
    rdy[N_STAGES] = m_axis_tready_i;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < N_STAGES; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? s_axis_tvalid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = vld_q[N_STAGES-1];

  gbl_cfg_regs #(
    .MAX_AXIS_BINS (MAX_AXIS_BINS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gbl_axis #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_axis_y (
    .clk_i    (clk_i),
    .en_i     (rdy[AXIS_STAGES-1:0]),
    .pos_i    (s_axis_tdata_i[23:0]),
    .half_i   (s_axis_tdata_i[70:48]),
    .origin_i (cfg.origin_y),
    .inv_i    (cfg.inv_y),
    .bin_c_o  (yb),
    .bin_lo_o (ylo),
    .bin_hi_o (yhi)
  );

  gbl_axis #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_axis_z (
    .clk_i    (clk_i),
    .en_i     (rdy[AXIS_STAGES-1:0]),
    .pos_i    (s_axis_tdata_i[47:24]),
    .half_i   (s_axis_tdata_i[93:71]),
    .origin_i (cfg.origin_z),
    .inv_i    (cfg.inv_z),
    .bin_c_o  (zb),
    .bin_lo_o (zlo),
    .bin_hi_o (zhi)
  );

  gbl_combine u_combine (
    .clk_i (clk_i),
    .en_i  (rdy[N_STAGES-1:AXIS_STAGES]),
    .cfg_i (cfg),
    .yb_i  (yb),
    .ylo_i (ylo),
    .yhi_i (yhi),
    .zb_i  (zb),
    .zlo_i (zlo),
    .zhi_i (zhi),
    .res_o (res)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(res);

`ifndef ASSERT_OFF
  // an accepted transfer always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted transfer not captured in first stage");

  // the stage before the output, held by the output stage, keeps its item
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[N_STAGES-2] && !rdy[N_STAGES-1] |=> vld_q[N_STAGES-2])
    else $error("item lost in a stalled stage");

  // after a result transfer the output is only valid if the stage before held one
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=> !m_axis_tvalid_o || $past(vld_q[N_STAGES-2]))
    else $error("result repeated without a new item");
`endif

endmodule

// File: sim/bin_lookup_check.sv
module bin_lookup_check import gbl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  // pos_y[23:0], pos_z[47:24], half_y[70:48], half_z[93:71], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  // flat_bin[15:0], outside[16], cell_y[24:17], cell_z[32:25],
  // area_start[48:33], area_span_y[56:49], area_span_z[64:57], zero pad
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  output int                     fail_cnt_o,
  output int                     pending_o
);

  localparam int unsigned PROD_SHIFT = COORD_FRAC_BITS_DEF + 16;
  localparam longint      BIN_SAT    = 65535;

  // grid registers as the block holds them
  logic signed [POS_W-1:0] org_y, org_z;
  logic [INV_W-1:0]        inv_y, inv_z;
  logic [CNT_W-1:0]        cnt_y, cnt_z;
  logic [TOT_W-1:0]        tot_bins;

  gbl_res_t bins_due[$];

  // truncate toward zero, then saturate the magnitude
  function automatic longint axis_bin_of(longint d, logic [INV_W-1:0] inv);
    longint unsigned mag, q;
    if (d < 0) mag = -d;
    else mag = d;
    q = (mag * inv) >> PROD_SHIFT;
    if (q > BIN_SAT) q = BIN_SAT;
    if (d < 0) return -longint'(q);
    return longint'(q);
  endfunction

  function automatic longint grid_count(logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_AXIS_BINS_DEF) return MAX_AXIS_BINS_DEF;
    return longint'(c);
  endfunction

  function automatic longint fit_bin(longint v, longint n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  function automatic gbl_res_t lookup_bins(logic [IN_TDATA_W-1:0] pt);
    logic signed [POS_W-1:0] py, pz;
    logic [HALF_W-1:0]       hy_f, hz_f;
    longint ny, nz, nt, ry, rz, hy, hz, yb, zb, flat, by, bz, sy, sz;
    gbl_res_t r;
    py   = pt[23:0];
    pz   = pt[47:24];
    hy_f = pt[70:48];
    hz_f = pt[93:71];
    ny = grid_count(cnt_y);
    nz = grid_count(cnt_z);
    nt = longint'(tot_bins);
    if (nt < 1) nt = 1;
    if (nt > 65536) nt = 65536;
    ry = longint'(py) - longint'(org_y);
    rz = longint'(pz) - longint'(org_z);
    hy = longint'(hy_f);
    hz = longint'(hz_f);
    yb = axis_bin_of(ry, inv_y);
    zb = axis_bin_of(rz, inv_z);
    flat = zb * ny + yb;
    r.outside  = (flat < 0 || flat >= nt);
    r.flat_bin = 16'(fit_bin(flat, nt));
    r.cell_y   = 8'(fit_bin(yb, ny));
    r.cell_z   = 8'(fit_bin(zb, nz));
    // span is measured from the unclamped lower bin and cut at the top only
    by = axis_bin_of(ry - hy, inv_y);
    sy = axis_bin_of(ry + hy, inv_y) - by;
    bz = axis_bin_of(rz - hz, inv_z);
    sz = axis_bin_of(rz + hz, inv_z) - bz;
    by = fit_bin(by, ny);
    bz = fit_bin(bz, nz);
    if (by + sy >= ny) sy = ny - 1 - by;
    if (bz + sz >= nz) sz = nz - 1 - bz;
    r.area_start  = 16'(bz * ny + by);
    r.area_span_y = 8'(sy);
    r.area_span_z = 8'(sz);
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    gbl_res_t got, want;
    if (!rst_ni) begin
      org_y    = '0;
      org_z    = '0;
      inv_y    = INV_STEP_RST;
      inv_z    = INV_STEP_RST;
      cnt_y    = CNT_W'(1);
      cnt_z    = CNT_W'(1);
      tot_bins = TOT_W'(1);
      bins_due.delete();
      fail_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_Y:   org_y    = cfg_wdata_i;
          CFG_ORIGIN_Z:   org_z    = cfg_wdata_i;
          CFG_INV_STEP_Y: inv_y    = cfg_wdata_i;
          CFG_INV_STEP_Z: inv_z    = cfg_wdata_i;
          CFG_COUNT_Y:    cnt_y    = cfg_wdata_i[CNT_W-1:0];
          CFG_COUNT_Z:    cnt_z    = cfg_wdata_i[CNT_W-1:0];
          CFG_TOTAL_BINS: tot_bins = cfg_wdata_i[TOT_W-1:0];
          default: ;
        endcase
      end
      // compare before queuing so a stray result cannot match a fresh item
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[$bits(gbl_res_t)-1:0];
        if (bins_due.size() == 0) begin
          $display("%0t unexpected result transfer, actual %h", $time, got);
          fail_cnt_o++;
        end else begin
          want = bins_due.pop_front();
          check_field("flat_bin", want.flat_bin, got.flat_bin);
          check_field("outside", want.outside, got.outside);
          check_field("cell_y", want.cell_y, got.cell_y);
          check_field("cell_z", want.cell_z, got.cell_z);
          check_field("area_start", want.area_start, got.area_start);
          check_field("area_span_y", want.area_span_y, got.area_span_y);
          check_field("area_span_z", want.area_span_z, got.area_span_z);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        bins_due.push_back(lookup_bins(s_axis_tdata_i));
      end
      pending_o <= bins_due.size();
    end
  end

endmodule

// File: sim/grid_bin_lookup_top_tb.sv
module grid_bin_lookup_top_tb;
  import gbl_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = N_STAGES + 8;
  localparam int unsigned IDLE_PCT       = 17;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS    = 64;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned STEADY_PHASE   = 2;
  localparam int unsigned HOLD_PHASE     = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam longint POS_MIN  = -8388608;
  localparam longint POS_MAX  = 8388607;
  localparam longint HALF_MAX = 8388607;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_wdata_i;

  int fail_cnt;
  int bins_pending;
  bit steady_flow;
  int hold_reqs;
  int holds_done;

  // grid as last written, used to aim random points at the bins
  longint grid_org_y, grid_org_z, grid_inv_y, grid_inv_z, grid_ny, grid_nz;

  grid_bin_lookup_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  bin_lookup_check u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (bins_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin : sink
    holds_done = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done < hold_reqs) begin
        holds_done++;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(value);
    @(negedge clk_i);
  endtask

  task automatic set_grid(longint oy, longint oz, longint iy, longint iz,
                          longint cy, longint cz, longint tot);
    logic signed [POS_W-1:0] oy_s, oz_s;
    longint ny, nz;
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_INV_STEP_Y, iy);
    write_reg(CFG_INV_STEP_Z, iz);
    write_reg(CFG_COUNT_Y, cy);
    write_reg(CFG_COUNT_Z, cz);
    write_reg(CFG_TOTAL_BINS, tot);
    cfg_we_i <= 1'b0;
    oy_s = POS_W'(oy);
    oz_s = POS_W'(oz);
    ny = longint'(cy) & 16'h1FF;
    nz = longint'(cz) & 16'h1FF;
    grid_org_y = longint'(oy_s);
    grid_org_z = longint'(oz_s);
    grid_inv_y = iy & 24'hFFFFFF;
    grid_inv_z = iz & 24'hFFFFFF;
    grid_ny = (ny == 0) ? 1 : (ny > MAX_AXIS_BINS_DEF) ? MAX_AXIS_BINS_DEF : ny;
    grid_nz = (nz == 0) ? 1 : (nz > MAX_AXIS_BINS_DEF) ? MAX_AXIS_BINS_DEF : nz;
  endtask

  task automatic send_point(longint py, longint pz, longint hy, longint hz);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, HALF_W'(hz), HALF_W'(hy), POS_W'(pz), POS_W'(py)};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // lets every lookup in flight come out before the grid changes
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (bins_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // edges of the fields, a point inside, a lower corner below the grid,
  // a small negative offset that truncates to bin zero
  task automatic send_corner_points();
    send_point(0, 2560, 256, 256);
    send_point(POS_MIN, POS_MIN, HALF_MAX, HALF_MAX);
    send_point(POS_MAX, POS_MAX, 0, 0);
    send_point(-2304, 1536, 768, 3000);
    send_point(-2816, 9472, 1, 1);
  endtask

  function automatic longint near_coord(longint org, longint inv, longint n);
    longint step, span, v;
    if (inv == 0 || $urandom_range(0, 9) < 3)
      return longint'($urandom_range(0, 16777215)) + POS_MIN;
    step = (longint'(1) << (COORD_FRAC_BITS_DEF + 16)) / inv;
    if (step < 1) step = 1;
    span = (n + 4) * step;
    if (span > 16777215) span = 16777215;
    v = org - 2 * step + longint'($urandom_range(0, int'(span)));
    if (v < POS_MIN) v = POS_MIN;
    if (v > POS_MAX) v = POS_MAX;
    return v;
  endfunction

  function automatic longint pick_half(longint inv);
    longint reach;
    case ($urandom_range(0, 9))
      0, 1:    return 0;
      2, 3, 4: return longint'($urandom_range(0, int'(HALF_MAX)));
      default: begin
        reach = (inv == 0) ? HALF_MAX : 3 * ((longint'(1) << 24) / inv);
        if (reach > HALF_MAX) reach = HALF_MAX;
        return longint'($urandom_range(0, int'(reach)));
      end
    endcase
  endfunction

  task automatic random_grid();
    longint oy, oz, iy, iz, cy, cz, tot;
    oy = longint'($urandom_range(0, 16777215)) + POS_MIN;
    oz = longint'($urandom_range(0, 16777215)) + POS_MIN;
    iy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215)
                                     : $urandom_range(1 << 12, 1 << 18);
    iz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215)
                                     : $urandom_range(1 << 12, 1 << 18);
    cy = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 20);
    cz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 20);
    tot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) : cy * cz;
    set_grid(oy, oz, iy, iz, cy, cz, tot);
  endtask

  initial begin : stimulus
    int phase;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    steady_flow     = 1'b0;
    hold_reqs       = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // grid registers at their reset values
    send_corner_points();
    settle();
    set_grid(-2560, 1280, 24'h008000, 24'h004000, 16, 8, 128);
    send_corner_points();
    settle();
    // largest grid, steepest y scale, flat z scale
    set_grid(POS_MIN, POS_MAX, 24'hFFFFFF, 0, 256, 256, 65536);
    send_corner_points();
    settle();
    // zero y count, z count over the limit and zero total; an unmapped index must change nothing
    set_grid(512, -512, 24'h000100, 24'h7FFFFF, 0, 511, 0);
    @(negedge clk_i);
    write_reg(CFG_IDX_UNUSED, 24'hABCDEF);
    cfg_we_i <= 1'b0;
    send_corner_points();
    settle();
    // high bits above the count field, count over the limit, total too big
    set_grid(0, 0, 24'h010000, 24'h020000, 24'hFFFE05, 300, 131071);
    send_corner_points();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      random_grid();
      steady_flow = (phase == STEADY_PHASE);
      if (phase == HOLD_PHASE) hold_reqs++;
      repeat (PHASE_ITEMS) begin
        send_point(near_coord(grid_org_y, grid_inv_y, grid_ny),
                   near_coord(grid_org_z, grid_inv_z, grid_nz),
                   pick_half(grid_inv_y), pick_half(grid_inv_z));
      end
    end
    steady_flow = 1'b0;
    settle();

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
